@@ sv/expression_lexer_unit_defines.svh @@
// Assertion macros shared by the expression lexer checkers.
// Needs a clock named clk and a reset named rst in the including scope.
`ifndef EXPRESSION_LEXER_UNIT_DEFINES_SVH
`define EXPRESSION_LEXER_UNIT_DEFINES_SVH

// Clocked assertion, switched off while reset is high.
`define EXLEX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define EXLEX_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/exlex_pkg.sv @@
// Expression lexer package: token kinds, codes, character constants, result record.
// No dependencies.
`timescale 1ns / 1ps

package exlex_pkg;

  // Source size and length limits
  localparam int unsigned MAX_SOURCE_BYTES = 65536;
  localparam int unsigned MAX_TOKEN_LEN    = 255;
  localparam int unsigned IDX_WRAP =
    (MAX_SOURCE_BYTES < 65536) ? MAX_SOURCE_BYTES : 65536;
  localparam logic [7:0]  LEN_CAP =
    8'((MAX_TOKEN_LEN < 255) ? MAX_TOKEN_LEN : 255);

  // Token kinds
  localparam logic [4:0] K_INT     = 5'd0;
  localparam logic [4:0] K_FLOAT   = 5'd1;
  localparam logic [4:0] K_IDENT   = 5'd2;
  localparam logic [4:0] K_KEYWORD = 5'd3;
  localparam logic [4:0] K_PLUS    = 5'd4;
  localparam logic [4:0] K_MINUS   = 5'd5;
  localparam logic [4:0] K_STAR    = 5'd6;
  localparam logic [4:0] K_SLASH   = 5'd7;
  localparam logic [4:0] K_CARET   = 5'd8;
  localparam logic [4:0] K_LPAREN  = 5'd9;
  localparam logic [4:0] K_RPAREN  = 5'd10;
  localparam logic [4:0] K_EE      = 5'd11;
  localparam logic [4:0] K_NE      = 5'd12;
  localparam logic [4:0] K_EQ      = 5'd13;
  localparam logic [4:0] K_LT      = 5'd14;
  localparam logic [4:0] K_LTE     = 5'd15;
  localparam logic [4:0] K_GT      = 5'd16;
  localparam logic [4:0] K_GTE     = 5'd17;
  localparam logic [4:0] K_EOF     = 5'd18;
  localparam logic [4:0] K_ERROR   = 5'd19;

  // Keyword ids
  localparam logic [1:0] KW_NONE = 2'd0;
  localparam logic [1:0] KW_AND  = 2'd1;
  localparam logic [1:0] KW_OR   = 2'd2;
  localparam logic [1:0] KW_NOT  = 2'd3;

  // Error codes
  localparam logic [1:0] E_NONE     = 2'd0;
  localparam logic [1:0] E_DECIMALS = 2'd1;
  localparam logic [1:0] E_BANG     = 2'd2;
  localparam logic [1:0] E_ILLEGAL  = 2'd3;

  // Keyword text, first characters in the upper bytes
  localparam logic [23:0] TXT_AND = 24'h616E64;
  localparam logic [23:0] TXT_OR  = 24'h006F72;
  localparam logic [23:0] TXT_NOT = 24'h6E6F74;

  // Characters
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;

  // One token as it leaves the block
  typedef struct packed {
    logic [4:0]  kind;
    logic [1:0]  kw;
    logic [15:0] idx;
    logic [15:0] line;
    logic [11:0] col;
    logic [7:0]  len;
    logic [1:0]  err;
    logic [7:0]  bad;
    logic        last;
  } token_t;

  function automatic token_t make_token(input logic [4:0] kind, input logic [1:0] kw,
                                        input logic [15:0] idx, input logic [15:0] line,
                                        input logic [11:0] col, input logic [7:0] len,
                                        input logic [1:0] err, input logic [7:0] bad,
                                        input logic last);
    token_t t;
    t.kind = kind;
    t.kw   = kw;
    t.idx  = idx;
    t.line = line;
    t.col  = col;
    t.len  = len;
    t.err  = err;
    t.bad  = bad;
    t.last = last;
    return t;
  endfunction

  // Keyword match on the first three characters of a word
  function automatic logic [1:0] keyword_of(input logic [7:0] len, input logic [23:0] txt);
    logic [1:0] kw;
    kw = KW_NONE;
    if (len == 8'd3 && txt == TXT_AND) kw = KW_AND;
    else if (len == 8'd2 && txt == TXT_OR) kw = KW_OR;
    else if (len == 8'd3 && txt == TXT_NOT) kw = KW_NOT;
    return kw;
  endfunction

endpackage

@@ sv/expression_lexer_unit.sv @@
// Expression lexer: one source byte per transaction in, tokens out, one per transaction.
// A token is queued as its closing byte is taken and offered when earlier tokens have left.
// Throughput: one byte per cycle while the 8-entry token queue has room for three
// tokens (the most one byte can produce); it drains one token per cycle with m_tready.
// Reset (rst, synchronous, active high) clears scan state, positions and the queue.
`timescale 1ns / 1ps

module expression_lexer_unit (
  input  logic        clk,
  input  logic        rst,
  // source side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] source_char
  input  logic        s_tlast,   // end_of_source
  // token side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [1:0] keyword_id, [17:2] start_index,
                                 // [33:18] start_line, [45:34] start_column,
                                 // [53:46] token_length, [55:54] error_code,
                                 // [63:56] bad_char
  output logic [4:0]  m_tuser,   // [4:0] token_kind
  output logic        m_tlast    // last_token
);

  import exlex_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE, M_NUM, M_ID, M_BANG, M_EQ, M_LT, M_GT, M_ERR
  } mode_t;

  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  // Scan state
  mode_t       mode, mode_next;
  logic        seen_dot, seen_dot_next;
  logic [15:0] rd_idx, rd_idx_next;
  logic [15:0] line_no, line_no_next;
  logic [11:0] col_no, col_no_next;
  logic [15:0] tok_idx, tok_idx_next;
  logic [15:0] tok_line, tok_line_next;
  logic [11:0] tok_col, tok_col_next;
  logic [7:0]  len, len_next;
  logic [23:0] kwbuf, kwbuf_next;

  // Per-byte decode
  logic [7:0]  c;
  logic        eos, again, ended;
  logic        is_digit, is_lower, is_word, is_space;
  logic [1:0]  n;
  token_t      res [3];
  logic [1:0]  kw_sel;

  // Token queue
  token_t           mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;
  logic             accept, pop;
  logic [1:0]       push_n;
  token_t           head;

  assign c        = s_tdata[7:0];
  assign eos      = s_tlast;
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_lower = (c >= CH_LO_A) && (c <= CH_LO_Z);
  assign is_word  = is_digit || is_lower || ((c >= CH_UP_A) && (c <= CH_UP_Z)) ||
                    (c == CH_UNDER);
  assign is_space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);

  // Everything one byte does, in the order the scanner would do it:
  // finish the pending token, start a new one, advance position, flush at end.
  always_comb begin
    mode_next     = mode;
    seen_dot_next = seen_dot;
    rd_idx_next   = rd_idx;
    line_no_next  = line_no;
    col_no_next   = col_no;
    tok_idx_next  = tok_idx;
    tok_line_next = tok_line;
    tok_col_next  = tok_col;
    len_next      = len;
    kwbuf_next    = kwbuf;
    n             = 2'd0;
    res[0]        = '0;
    res[1]        = '0;
    res[2]        = '0;
    again         = 1'b0;
    ended         = 1'b0;
    kw_sel        = KW_NONE;

    if (mode == M_ERR) begin
      // swallow bytes until end of source, then back to reset
      if (eos) begin
        mode_next     = M_IDLE;
        seen_dot_next = 1'b0;
        rd_idx_next   = '0;
        line_no_next  = '0;
        col_no_next   = '0;
        tok_idx_next  = '0;
        tok_line_next = '0;
        tok_col_next  = '0;
        len_next      = '0;
        kwbuf_next    = '0;
      end
    end else begin
      unique case (mode)
        M_NUM: begin
          if (is_digit || c == CH_DOT) begin
            if (c == CH_DOT && seen_dot) begin
              res[n] = make_token(K_ERROR, KW_NONE, rd_idx, line_no, col_no, 8'd1,
                                  E_DECIMALS, 8'd0, 1'b1);
              n = n + 2'd1;
              mode_next = M_ERR;
            end else begin
              if (c == CH_DOT) seen_dot_next = 1'b1;
              if (len < 8'd3) kwbuf_next = {kwbuf[15:0], c};
              if (len < LEN_CAP) len_next = len + 8'd1;
            end
          end else begin
            res[n] = make_token(seen_dot ? K_FLOAT : K_INT, KW_NONE, tok_idx, tok_line,
                                tok_col, len, E_NONE, 8'd0, 1'b0);
            n = n + 2'd1;
            again = 1'b1;
          end
        end
        M_ID: begin
          if (is_word) begin
            if (len < 8'd3) kwbuf_next = {kwbuf[15:0], c};
            if (len < LEN_CAP) len_next = len + 8'd1;
          end else begin
            kw_sel = keyword_of(len, kwbuf);
            res[n] = make_token((kw_sel != KW_NONE) ? K_KEYWORD : K_IDENT, kw_sel, tok_idx,
                                tok_line, tok_col, len, E_NONE, 8'd0, 1'b0);
            n = n + 2'd1;
            again = 1'b1;
          end
        end
        M_BANG: begin
          if (c == CH_EQ) begin
            res[n] = make_token(K_NE, KW_NONE, tok_idx, tok_line, tok_col, 8'd2,
                                E_NONE, 8'd0, 1'b0);
            mode_next = M_IDLE;
          end else begin
            res[n] = make_token(K_ERROR, KW_NONE, tok_idx, tok_line, tok_col, 8'd2,
                                E_BANG, 8'd0, 1'b1);
            mode_next = M_ERR;
          end
          n = n + 2'd1;
        end
        M_EQ, M_LT, M_GT: begin
          if (c == CH_EQ) begin
            res[n] = make_token((mode == M_EQ) ? K_EE : (mode == M_LT) ? K_LTE : K_GTE,
                                KW_NONE, tok_idx, tok_line, tok_col, 8'd2, E_NONE, 8'd0,
                                1'b0);
            mode_next = M_IDLE;
          end else begin
            res[n] = make_token((mode == M_EQ) ? K_EQ : (mode == M_LT) ? K_LT : K_GT,
                                KW_NONE, tok_idx, tok_line, tok_col, 8'd1, E_NONE, 8'd0,
                                1'b0);
            again = 1'b1;
          end
          n = n + 2'd1;
        end
        default: again = 1'b1;
      endcase

      // byte not consumed by the pending token: treat it as a fresh start
      if (again) begin
        mode_next = M_IDLE;
        if (!is_space) begin
          if (is_digit || is_lower) begin
            mode_next     = is_digit ? M_NUM : M_ID;
            tok_idx_next  = rd_idx;
            tok_line_next = line_no;
            tok_col_next  = col_no;
            len_next      = 8'd1;
            seen_dot_next = 1'b0;
            kwbuf_next    = {16'd0, c};
          end else begin
            unique case (c)
              CH_BANG, CH_EQ, CH_LT, CH_GT: begin
                mode_next     = (c == CH_BANG) ? M_BANG : (c == CH_EQ) ? M_EQ :
                                (c == CH_LT) ? M_LT : M_GT;
                tok_idx_next  = rd_idx;
                tok_line_next = line_no;
                tok_col_next  = col_no;
                len_next      = 8'd1;
                seen_dot_next = 1'b0;
                kwbuf_next    = {16'd0, c};
              end
              CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET, CH_LPAREN, CH_RPAREN: begin
                res[n] = make_token((c == CH_PLUS)  ? K_PLUS  : (c == CH_MINUS) ? K_MINUS :
                                    (c == CH_STAR)  ? K_STAR  : (c == CH_SLASH) ? K_SLASH :
                                    (c == CH_CARET) ? K_CARET :
                                    (c == CH_LPAREN) ? K_LPAREN : K_RPAREN,
                                    KW_NONE, rd_idx, line_no, col_no, 8'd1, E_NONE, 8'd0,
                                    1'b0);
                n = n + 2'd1;
              end
              default: begin
                res[n] = make_token(K_ERROR, KW_NONE, rd_idx, line_no, col_no, 8'd1,
                                    E_ILLEGAL, c, 1'b1);
                n = n + 2'd1;
                mode_next = M_ERR;
              end
            endcase
          end
        end
      end

      // position of the next byte
      if ({1'b0, rd_idx} + 17'd1 == 17'(IDX_WRAP)) rd_idx_next = '0;
      else rd_idx_next = rd_idx + 16'd1;
      if (c == CH_NL) begin
        line_no_next = line_no + 16'd1;
        col_no_next  = '0;
      end else begin
        col_no_next  = col_no + 12'd1;
      end

      // end of source: flush the pending token, then EOF unless an error ended it
      if (eos) begin
        ended = (mode_next == M_ERR);
        unique case (mode_next)
          M_NUM: begin
            res[n] = make_token(seen_dot_next ? K_FLOAT : K_INT, KW_NONE, tok_idx_next,
                                tok_line_next, tok_col_next, len_next, E_NONE, 8'd0, 1'b0);
            n = n + 2'd1;
          end
          M_ID: begin
            kw_sel = keyword_of(len_next, kwbuf_next);
            res[n] = make_token((kw_sel != KW_NONE) ? K_KEYWORD : K_IDENT, kw_sel,
                                tok_idx_next, tok_line_next, tok_col_next, len_next,
                                E_NONE, 8'd0, 1'b0);
            n = n + 2'd1;
          end
          M_BANG: begin
            res[n] = make_token(K_ERROR, KW_NONE, tok_idx_next, tok_line_next,
                                tok_col_next, 8'd1, E_BANG, 8'd0, 1'b1);
            n = n + 2'd1;
            ended = 1'b1;
          end
          M_EQ, M_LT, M_GT: begin
            res[n] = make_token((mode_next == M_EQ) ? K_EQ :
                                (mode_next == M_LT) ? K_LT : K_GT,
                                KW_NONE, tok_idx_next, tok_line_next, tok_col_next, 8'd1,
                                E_NONE, 8'd0, 1'b0);
            n = n + 2'd1;
          end
          default: ;
        endcase
        if (!ended) begin
          res[n] = make_token(K_EOF, KW_NONE, rd_idx_next, line_no_next, col_no_next,
                              8'd0, E_NONE, 8'd0, 1'b1);
          n = n + 2'd1;
        end
        mode_next     = M_IDLE;
        seen_dot_next = 1'b0;
        rd_idx_next   = '0;
        line_no_next  = '0;
        col_no_next   = '0;
        tok_idx_next  = '0;
        tok_line_next = '0;
        tok_col_next  = '0;
        len_next      = '0;
        kwbuf_next    = '0;
      end
    end
  end

  // Take a byte only when the queue can hold its worst case of three tokens.
  assign s_tready = (count <= (PTR_W+1)'(FIFO_DEPTH - 3));
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = (count != '0);
  assign pop      = m_tvalid && m_tready;
  assign push_n   = accept ? n : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= M_IDLE;
      seen_dot <= 1'b0;
      rd_idx   <= '0;
      line_no  <= '0;
      col_no   <= '0;
      tok_idx  <= '0;
      tok_line <= '0;
      tok_col  <= '0;
      len      <= '0;
      kwbuf    <= '0;
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      count    <= '0;
    end else begin
      if (accept) begin
        mode     <= mode_next;
        seen_dot <= seen_dot_next;
        rd_idx   <= rd_idx_next;
        line_no  <= line_no_next;
        col_no   <= col_no_next;
        tok_idx  <= tok_idx_next;
        tok_line <= tok_line_next;
        tok_col  <= tok_col_next;
        len      <= len_next;
        kwbuf    <= kwbuf_next;
      end
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      count  <= count + (PTR_W+1)'(push_n) - (PTR_W+1)'(pop);
    end
  end

  // Token storage: up to three writes per cycle at consecutive slots.
  always_ff @(posedge clk) begin
    if (push_n > 2'd0) mem[wr_ptr]              <= res[0];
    if (push_n > 2'd1) mem[wr_ptr + PTR_W'(1)]  <= res[1];
    if (push_n > 2'd2) mem[wr_ptr + PTR_W'(2)]  <= res[2];
  end

  assign head    = mem[rd_ptr];
  assign m_tuser = head.kind;
  assign m_tlast = head.last;
  assign m_tdata = {head.bad, head.err, head.len, head.col, head.line, head.idx, head.kw};

endmodule

@@ sv/exlex_checker.sv @@
// Port-level checks on the token side of the expression lexer, bound to the top level.
// Depends on exlex_pkg and expression_lexer_unit_defines.svh.
`timescale 1ns / 1ps
`include "expression_lexer_unit_defines.svh"

module exlex_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic [4:0]  m_tuser,
  input logic        m_tlast
);

  import exlex_pkg::*;

  // stalled token holds
  `EXLEX_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "token changed while stalled")

  // only EOF or an error closes a source
  `EXLEX_ASSERT(a_last_kind, m_tvalid && m_tlast |-> (m_tuser == K_EOF) || (m_tuser == K_ERROR), "last flag on a plain token")

  // EOF is always last and has no length
  `EXLEX_ASSERT(a_eof, m_tvalid && (m_tuser == K_EOF) |-> m_tlast && (m_tdata[53:46] == 8'd0), "malformed EOF token")

  // error tokens carry a code and end the source
  `EXLEX_ASSERT(a_error, m_tvalid && (m_tuser == K_ERROR) |-> m_tlast && (m_tdata[55:54] != E_NONE), "error token without code")

  // nothing offered in the cycle after reset
  `EXLEX_ASSERT_ALWAYS(a_reset, $past(rst) |-> !m_tvalid, "token offered straight after reset")

endmodule

bind expression_lexer_unit exlex_checker u_exlex_checker (.*);
